// ===== rtl/uer_pkg.sv =====
// shared types and constants for the four-channel echo ranger
package uer_pkg;

    localparam int NUM_SENSORS = 4;
    localparam int SENSOR_W = 2;
    localparam int RANGE_W = 16;
    localparam int TICK_W = 16;
    localparam int TIME_W = 32;
    localparam int TIMEOUT_W = 10;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    localparam logic [TICK_W-1:0] LOW_WIDTH = 16'd116;
    localparam logic [TICK_W-1:0] HIGH_WIDTH = 16'd23200;
    localparam logic [17:0] MM_ROUND = 18'd29;
    // ceil(2^24 / 58), exact floor division for numerators below 2^18
    localparam logic [18:0] MM_RECIP = 19'd289263;
    localparam int MM_SHIFT = 24;

    localparam logic [NUM_SENSORS-1:0] ALL_DONE = 4'hF;
    localparam logic [RANGE_W-1:0] UNAVAIL_RESET = 16'hFFFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd30;

    typedef enum logic {
        CFG_UNAVAIL_CODE = 1'b0,
        CFG_ECHO_TIMEOUT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [RANGE_W-1:0]   unavail_code;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic                 mode;
        logic [NUM_SENSORS-1:0] pending_mask;
        logic [TICK_W-1:0]    capture_us;
        logic [TIME_W-1:0]    now_ms;
    } item_t;

    typedef struct packed {
        logic                                 scan_done;
        logic [NUM_SENSORS-1:0][RANGE_W-1:0]  range;
        logic                                 trigger_start;
        logic [SENSOR_W-1:0]                  trigger_sensor;
        logic                                 watch_falling;
    } res_t;

endpackage

// ===== rtl/uer_width_conv.sv =====
// echo pulse width to millimetres, (w*10+29)/58 by reciprocal multiply
module uer_width_conv
    import uer_pkg::*;
(
    input  logic [TICK_W-1:0]  width_us,
    input  logic [RANGE_W-1:0] unavail_code,
    output logic [RANGE_W-1:0] range_mm
);

    logic [17:0] numer;
    logic [36:0] prod;
    logic        in_window;

    assign numer = ({2'b00, width_us} << 3) + ({2'b00, width_us} << 1) + MM_ROUND;
    assign prod = {19'd0, numer} * {18'd0, MM_RECIP};
    assign in_window = (width_us >= LOW_WIDTH) && (width_us <= HIGH_WIDTH);
    assign range_mm = in_window ? prod[MM_SHIFT +: RANGE_W] : unavail_code;

endmodule

// ===== rtl/uer_ctrl.sv =====
// sensor sequencing state and per-word update
module uer_ctrl
    import uer_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  advance,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    logic                   busy_reg, busy_next;
    logic [SENSOR_W-1:0]    active_sensor_reg, active_sensor_next;
    logic                   waiting_fall_reg, waiting_fall_next;
    logic [TICK_W-1:0]      rise_tick_reg, rise_tick_next;
    logic [RANGE_W-1:0]     range_reg [NUM_SENSORS];
    logic [RANGE_W-1:0]     range_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] done_mask_reg, done_mask_next;
    logic [TIME_W-1:0]      start_time_reg, start_time_next;
    logic [SENSOR_W-1:0]    next_sensor_reg, next_sensor_next;

    logic [TICK_W-1:0]      echo_width;
    logic [RANGE_W-1:0]     conv_mm;
    logic [TIME_W-1:0]      elapsed;
    logic                   fin_en;
    logic [RANGE_W-1:0]     fin_val;

    assign echo_width = item.capture_us - rise_tick_reg;
    assign elapsed = item.now_ms - start_time_reg;

    uer_width_conv u_conv (
        .width_us     (echo_width),
        .unavail_code (cfg.unavail_code),
        .range_mm     (conv_mm)
    );

    always_comb begin
        busy_next = busy_reg;
        active_sensor_next = active_sensor_reg;
        waiting_fall_next = waiting_fall_reg;
        rise_tick_next = rise_tick_reg;
        done_mask_next = done_mask_reg;
        start_time_next = start_time_reg;
        next_sensor_next = next_sensor_reg;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            range_next[i] = range_reg[i];
        end
        fin_en = 1'b0;
        fin_val = cfg.unavail_code;
        res = '0;

        if (item.mode == MODE_CAPTURE) begin
            if (busy_reg && item.pending_mask[active_sensor_reg]) begin
                if (!waiting_fall_reg) begin
                    rise_tick_next = item.capture_us;
                    waiting_fall_next = 1'b1;
                end else begin
                    fin_en = 1'b1;
                    fin_val = conv_mm;
                end
            end
        end else begin
            if (busy_reg && (elapsed >= {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout_ms})) begin
                fin_en = 1'b1;
            end
        end

        if (fin_en) begin
            range_next[active_sensor_reg] = fin_val;
            done_mask_next = done_mask_reg
                | (NUM_SENSORS'(1) << active_sensor_reg);
            waiting_fall_next = 1'b0;
            busy_next = 1'b0;
        end

        if (item.mode == MODE_POLL) begin
            if (done_mask_next == ALL_DONE) begin
                res.scan_done = 1'b1;
                for (int i = 0; i < NUM_SENSORS; i++) begin
                    res.range[i] = range_next[i];
                end
                done_mask_next = '0;
            end
            if (!busy_next) begin
                busy_next = 1'b1;
                active_sensor_next = next_sensor_reg;
                waiting_fall_next = 1'b0;
                start_time_next = item.now_ms;
                next_sensor_next = next_sensor_reg + SENSOR_W'(1);
                res.trigger_start = 1'b1;
            end
        end

        res.trigger_sensor = active_sensor_next;
        res.watch_falling = waiting_fall_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            active_sensor_reg <= '0;
            waiting_fall_reg <= 1'b0;
            rise_tick_reg <= '0;
            done_mask_reg <= '0;
            start_time_reg <= '0;
            next_sensor_reg <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                range_reg[i] <= UNAVAIL_RESET;
            end
        end else if (advance) begin
            busy_reg <= busy_next;
            active_sensor_reg <= active_sensor_next;
            waiting_fall_reg <= waiting_fall_next;
            rise_tick_reg <= rise_tick_next;
            done_mask_reg <= done_mask_next;
            start_time_reg <= start_time_next;
            next_sensor_reg <= next_sensor_next;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                range_reg[i] <= range_next[i];
            end
        end
    end

endmodule

// ===== rtl/ultrasonic_echo_ranger_4ch.sv =====
// top level of the four-channel round-robin echo ranger
// Each input word is either a capture event (edge timestamp plus pending
// capture flags) or a poll (current millisecond time), and each gives exactly
// one result word. The block sustains one word per clock while the output is
// not stalled: a word waits in the input register, the sensor state and range
// conversion are updated in a single combinational pass (one 18x19 reciprocal
// multiply for the millimetre conversion), and the result is held in the
// output register, so a result word passes through both registers before it
// is presented and is taken at an edge where m_ready is high. While a result
// waits to be read, the input register takes one more word and then holds
// s_ready low. Configuration writes are taken at any edge with cfg_we high and
// must only occur while no word is in flight.
module ultrasonic_echo_ranger_4ch
    import uer_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [RANGE_W-1:0]   cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [NUM_SENSORS-1:0] s_pending_mask,
    input  logic [TICK_W-1:0]    s_capture_us,
    input  logic [TIME_W-1:0]    s_now_ms,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_scan_done,
    output logic [RANGE_W-1:0]   m_range_front,
    output logic [RANGE_W-1:0]   m_range_rear,
    output logic [RANGE_W-1:0]   m_range_left,
    output logic [RANGE_W-1:0]   m_range_right,
    output logic                 m_trigger_start,
    output logic [SENSOR_W-1:0]  m_trigger_sensor,
    output logic                 m_watch_falling
);

    cfg_t  cfg_reg;
    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  m_valid_reg, m_valid_next;
    res_t  res_reg;
    res_t  res_comb;
    logic  advance;
    logic  s_fire;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire = s_valid && s_ready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unavail_code <= UNAVAIL_RESET;
            cfg_reg.timeout_ms <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_UNAVAIL_CODE: cfg_reg.unavail_code <= cfg_wdata;
                CFG_ECHO_TIMEOUT: cfg_reg.timeout_ms <= cfg_wdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // input word register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.mode <= s_mode;
            in_item_reg.pending_mask <= s_pending_mask;
            in_item_reg.capture_us <= s_capture_us;
            in_item_reg.now_ms <= s_now_ms;
        end
    end

    uer_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res_comb)
    );

    // result word register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_scan_done = res_reg.scan_done;
    assign m_range_front = res_reg.range[0];
    assign m_range_rear = res_reg.range[1];
    assign m_range_left = res_reg.range[2];
    assign m_range_right = res_reg.range[3];
    assign m_trigger_start = res_reg.trigger_start;
    assign m_trigger_sensor = res_reg.trigger_sensor;
    assign m_watch_falling = res_reg.watch_falling;

endmodule

// ===== rtl/uer_checker.sv =====
// port-level checks for the echo ranger, bound to the top level
module uer_checker
    import uer_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_scan_done,
    input logic [RANGE_W-1:0]  m_range_front,
    input logic [RANGE_W-1:0]  m_range_rear,
    input logic [RANGE_W-1:0]  m_range_left,
    input logic [RANGE_W-1:0]  m_range_right,
    input logic                m_trigger_start,
    input logic [SENSOR_W-1:0] m_trigger_sensor,
    input logic                m_watch_falling
);

    // no result word right after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scan_done)
            && $stable(m_range_front) && $stable(m_trigger_sensor)
            && $stable(m_trigger_start) && $stable(m_watch_falling))
        else $error("stalled result word changed");

    // ranges are zero unless a snapshot is reported
    a_ranges_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_scan_done |-> m_range_front == '0 && m_range_rear == '0
            && m_range_left == '0 && m_range_right == '0)
        else $error("range shown without snapshot");

    // a freshly triggered sensor waits for its rising edge
    a_trigger_watch_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_trigger_start |-> !m_watch_falling)
        else $error("trigger word with falling polarity");

endmodule

bind ultrasonic_echo_ranger_4ch uer_checker u_uer_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_scan_done      (m_scan_done),
    .m_range_front    (m_range_front),
    .m_range_rear     (m_range_rear),
    .m_range_left     (m_range_left),
    .m_range_right    (m_range_right),
    .m_trigger_start  (m_trigger_start),
    .m_trigger_sensor (m_trigger_sensor),
    .m_watch_falling  (m_watch_falling)
);

// ===== sim/ultrasonic_echo_ranger_4ch_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the four-channel round-robin echo ranger
module ultrasonic_echo_ranger_4ch_tb
    import uer_pkg::*;
();

    typedef struct {
        item_t it;
        bit    fixed;
        res_t  want;
    } stim_row_t;

    localparam res_t NO_RES = '0;
    localparam int DIR_ROWS = 24;
    localparam int PHASES = 5;
    localparam int PHASE_WORDS = 225;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic cfg_addr;
    logic [RANGE_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_mode;
    logic [NUM_SENSORS-1:0] s_pending_mask;
    logic [TICK_W-1:0] s_capture_us;
    logic [TIME_W-1:0] s_now_ms;
    logic m_valid;
    logic m_ready;
    logic m_scan_done;
    logic [RANGE_W-1:0] m_range_front;
    logic [RANGE_W-1:0] m_range_rear;
    logic [RANGE_W-1:0] m_range_left;
    logic [RANGE_W-1:0] m_range_right;
    logic m_trigger_start;
    logic [SENSOR_W-1:0] m_trigger_sensor;
    logic m_watch_falling;

    // predictor state
    logic [RANGE_W-1:0] cur_unavail;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic pr_busy;
    logic [SENSOR_W-1:0] pr_active;
    logic pr_waiting_fall;
    logic [TICK_W-1:0] pr_rise_tick;
    logic [RANGE_W-1:0] pr_ranges [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] pr_done;
    logic [TIME_W-1:0] pr_start_time;
    logic [SENSOR_W-1:0] pr_next;

    res_t reports_due [$];
    res_t want_now;
    stim_row_t dir_rows [DIR_ROWS];
    logic [TIME_W-1:0] clock_ms;
    logic [TICK_W-1:0] rim_widths [4] = '{16'd115, 16'd116, 16'd23200, 16'd23201};
    logic [RANGE_W-1:0] phase_code [PHASES] =
        '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h8001};
    logic [TIMEOUT_W-1:0] phase_timeout [PHASES] =
        '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd30};
    bit calm = 1'b0;
    int fail_count = 0;

    ultrasonic_echo_ranger_4ch DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_pending_mask(s_pending_mask),
        .s_capture_us(s_capture_us),
        .s_now_ms(s_now_ms),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_scan_done(m_scan_done),
        .m_range_front(m_range_front),
        .m_range_rear(m_range_rear),
        .m_range_left(m_range_left),
        .m_range_right(m_range_right),
        .m_trigger_start(m_trigger_start),
        .m_trigger_sensor(m_trigger_sensor),
        .m_watch_falling(m_watch_falling)
    );

    always #1 aclk = ~aclk;

    function automatic item_t cap_w(logic [NUM_SENSORS-1:0] pm, logic [TICK_W-1:0] us);
        item_t it;
        it = '0;
        it.mode = MODE_CAPTURE;
        it.pending_mask = pm;
        it.capture_us = us;
        return it;
    endfunction

    function automatic item_t poll_w(logic [TIME_W-1:0] now);
        item_t it;
        it = '0;
        it.mode = MODE_POLL;
        it.now_ms = now;
        return it;
    endfunction

    function automatic res_t outcome(logic rdy, logic [4*RANGE_W-1:0] ranges, logic trig,
                                     logic [SENSOR_W-1:0] sensor, logic watch);
        res_t r;
        r.scan_done = rdy;
        r.range = ranges;
        r.trigger_start = trig;
        r.trigger_sensor = sensor;
        r.watch_falling = watch;
        return r;
    endfunction

    function automatic logic [RANGE_W-1:0] echo_to_mm(logic [TICK_W-1:0] w);
        if (w >= LOW_WIDTH && w <= HIGH_WIDTH) begin
            return RANGE_W'((32'(w) * 10 + 29) / 58);
        end
        return cur_unavail;
    endfunction

    function automatic void close_sensor(logic [RANGE_W-1:0] value);
        pr_ranges[pr_active] = value;
        pr_done[pr_active] = 1'b1;
        pr_waiting_fall = 1'b0;
        pr_busy = 1'b0;
    endfunction

    function automatic res_t ranger_step(item_t it);
        res_t r;
        r = '0;
        if (it.mode == MODE_CAPTURE) begin
            if (pr_busy && it.pending_mask[pr_active]) begin
                if (!pr_waiting_fall) begin
                    pr_rise_tick = it.capture_us;
                    pr_waiting_fall = 1'b1;
                end else begin
                    close_sensor(echo_to_mm(it.capture_us - pr_rise_tick));
                end
            end
        end else begin
            if (pr_busy && (it.now_ms - pr_start_time) >= {22'd0, cur_timeout}) begin
                close_sensor(cur_unavail);
            end
            if (pr_done == ALL_DONE) begin
                r.scan_done = 1'b1;
                for (int i = 0; i < NUM_SENSORS; i++) begin
                    r.range[i] = pr_ranges[i];
                end
                pr_done = '0;
            end
            if (!pr_busy) begin
                pr_busy = 1'b1;
                pr_active = pr_next;
                pr_waiting_fall = 1'b0;
                pr_start_time = it.now_ms;
                pr_next = pr_next + 1'b1;
                r.trigger_start = 1'b1;
            end
        end
        r.trigger_sensor = pr_active;
        r.watch_falling = pr_waiting_fall;
        return r;
    endfunction

    // mostly well-formed rise/fall/poll sequences, some noise
    function automatic item_t next_item();
        item_t it;
        int unsigned pick;
        logic [TICK_W-1:0] gap_us;
        pick = $urandom_range(0, 99);
        it = '0;
        if (pick < 15) begin
            it.mode = 1'($urandom);
            it.pending_mask = NUM_SENSORS'($urandom);
            it.capture_us = TICK_W'($urandom);
            it.now_ms = $urandom;
        end else if (!pr_busy || pick < 35) begin
            it.mode = MODE_POLL;
            if ($urandom_range(0, 3) == 0) begin
                clock_ms += $urandom_range(0, 2 * cur_timeout + 2);
            end else begin
                clock_ms += $urandom_range(0, 3);
            end
            it.now_ms = clock_ms;
            it.pending_mask = NUM_SENSORS'($urandom);
            it.capture_us = TICK_W'($urandom);
        end else begin
            it.mode = MODE_CAPTURE;
            it.pending_mask = NUM_SENSORS'($urandom);
            it.pending_mask[pr_active] = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 5))
                0: gap_us = TICK_W'($urandom);
                1: gap_us = rim_widths[2'($urandom_range(0, 3))];
                default: gap_us = TICK_W'($urandom_range(116, 23200));
            endcase
            it.capture_us = pr_waiting_fall ? pr_rise_tick + gap_us : TICK_W'($urandom);
            it.now_ms = $urandom;
        end
        return it;
    endfunction

    task automatic push_word(item_t it, bit fixed, res_t want);
        logic rdy;
        res_t got;
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_pending_mask <= it.pending_mask;
        s_capture_us <= it.capture_us;
        s_now_ms <= it.now_ms;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        got = ranger_step(it);
        reports_due.push_back(fixed ? want : got);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(logic [RANGE_W-1:0] code, logic [TIMEOUT_W-1:0] tmo);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_UNAVAIL_CODE;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_addr <= CFG_ECHO_TIMEOUT;
        cfg_wdata <= {{(RANGE_W-TIMEOUT_W){1'b0}}, tmo};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_unavail = code;
        cur_timeout = tmo;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("result word with nothing pending");
                    fail_count++;
                end else begin
                    want_now = reports_due.pop_front();
                    check_field("scan_done", 32'(want_now.scan_done), 32'(m_scan_done));
                    check_field("range_front", 32'(want_now.range[0]), 32'(m_range_front));
                    check_field("range_rear", 32'(want_now.range[1]), 32'(m_range_rear));
                    check_field("range_left", 32'(want_now.range[2]), 32'(m_range_left));
                    check_field("range_right", 32'(want_now.range[3]), 32'(m_range_right));
                    check_field("trigger_start", 32'(want_now.trigger_start),
                                32'(m_trigger_start));
                    check_field("trigger_sensor", 32'(want_now.trigger_sensor),
                                32'(m_trigger_sensor));
                    check_field("watch_falling", 32'(want_now.watch_falling),
                                32'(m_watch_falling));
                end
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    initial begin
        #1000000;
        $display("ultrasonic_echo_ranger_4ch_tb: errors");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_UNAVAIL_CODE;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_mode <= MODE_CAPTURE;
        s_pending_mask <= '0;
        s_capture_us <= '0;
        s_now_ms <= '0;

        cur_unavail = UNAVAIL_RESET;
        cur_timeout = TIMEOUT_RESET;
        pr_busy = 1'b0;
        pr_active = '0;
        pr_waiting_fall = 1'b0;
        pr_rise_tick = '0;
        for (int i = 0; i < NUM_SENSORS; i++) pr_ranges[i] = UNAVAIL_RESET;
        pr_done = '0;
        pr_start_time = '0;
        pr_next = '0;

        // capture while idle, missing active flag, window edges, wrap of both counters
        dir_rows[0] = '{cap_w(4'hF, 16'h1234), 1'b1,
                        outcome(1'b0, '0, 1'b0, 2'd0, 1'b0)};
        dir_rows[1] = '{poll_w(32'd0), 1'b1, outcome(1'b0, '0, 1'b1, 2'd0, 1'b0)};
        dir_rows[2] = '{cap_w(4'hE, 16'h0000), 1'b1,
                        outcome(1'b0, '0, 1'b0, 2'd0, 1'b0)};
        dir_rows[3] = '{cap_w(4'h1, 16'hFFF0), 1'b1,
                        outcome(1'b0, '0, 1'b0, 2'd0, 1'b1)};
        dir_rows[4] = '{cap_w(4'h1, 16'h0064), 1'b0, NO_RES};
        dir_rows[5] = '{poll_w(32'd5), 1'b1, outcome(1'b0, '0, 1'b1, 2'd1, 1'b0)};
        dir_rows[6] = '{cap_w(4'h2, 16'd0), 1'b0, NO_RES};
        dir_rows[7] = '{cap_w(4'h2, 16'd23200), 1'b0, NO_RES};
        dir_rows[8] = '{poll_w(32'd10), 1'b0, NO_RES};
        dir_rows[9] = '{cap_w(4'h4, 16'd100), 1'b0, NO_RES};
        dir_rows[10] = '{cap_w(4'h4, 16'd215), 1'b0, NO_RES};
        dir_rows[11] = '{poll_w(32'd20), 1'b0, NO_RES};
        dir_rows[12] = '{cap_w(4'h8, 16'd0), 1'b0, NO_RES};
        dir_rows[13] = '{cap_w(4'h8, 16'd23201), 1'b0, NO_RES};
        dir_rows[14] = '{poll_w(32'd21), 1'b1,
                         outcome(1'b1, {16'd65535, 16'd65535, 16'd4000, 16'd20}, 1'b1,
                                 2'd0, 1'b0)};
        dir_rows[15] = '{poll_w(32'd50), 1'b0, NO_RES};
        dir_rows[16] = '{poll_w(32'd51), 1'b0, NO_RES};
        dir_rows[17] = '{poll_w(32'hFFFF_FFFF), 1'b0, NO_RES};
        dir_rows[18] = '{poll_w(32'h0000_001C), 1'b0, NO_RES};
        dir_rows[19] = '{cap_w(4'h4, 16'hFFFF), 1'b0, NO_RES};
        dir_rows[20] = '{poll_w(32'h0000_001D), 1'b0, NO_RES};
        dir_rows[21] = '{cap_w(4'h8, 16'hFFFF), 1'b0, NO_RES};
        dir_rows[22] = '{cap_w(4'h8, 16'hFFFF), 1'b0, NO_RES};
        dir_rows[23] = '{poll_w(32'h0000_0020), 1'b1,
                         outcome(1'b1, {4{16'hFFFF}}, 1'b1, 2'd0, 1'b0)};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            push_word(dir_rows[r].it, dir_rows[r].fixed, dir_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_regs(phase_code[p], phase_timeout[p]);
            clock_ms = (p == 3) ? 32'hFFFF_FE00 : TIME_W'($urandom);
            if (p == PHASES - 1) calm = 1'b1;
            repeat (PHASE_WORDS) push_word(next_item(), 1'b0, NO_RES);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ultrasonic_echo_ranger_4ch_tb: clean");
        end else begin
            $display("ultrasonic_echo_ranger_4ch_tb: errors");
        end
        $finish;
    end

endmodule

// ===== ultrasonic_echo_ranger_4ch.f =====
rtl/uer_pkg.sv
rtl/uer_width_conv.sv
rtl/uer_ctrl.sv
rtl/ultrasonic_echo_ranger_4ch.sv
rtl/uer_checker.sv
sim/ultrasonic_echo_ranger_4ch_tb.sv
